// ===== hdl/tlca_pkg.sv =====
package tlca_pkg;

	localparam int MAX_NODES = 1024;
	localparam int LEVELS    = 10;
	localparam int NW        = 11;                       // node id, counter width
	localparam int SW        = $clog2(MAX_NODES);        // stack index
	localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int JW        = LW + NW;                  // jump table address

	typedef logic [NW-1:0] node_t;
	typedef logic [LW-1:0] lvl_t;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_BUILD = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_code_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLR_INIT,
		OP_CLR,
		OP_LINK_INIT,
		OP_LINK_RD,
		OP_LINK_P,
		OP_LINK_W,
		OP_DFS_INIT,
		OP_DFS_RD,
		OP_DFS_RDNS,
		OP_DFS_PUSH,
		OP_DFS_POP,
		OP_DFS_TOP,
		OP_JMP_INIT,
		OP_JMP_R1,
		OP_JMP_R2,
		OP_JMP_W,
		OP_Q_RD_B,
		OP_Q_RD_A,
		OP_Q_LOOP,
		OP_Q_UP,
		OP_Q_STEP,
		OP_OUT_A,
		OP_OUT_J,
		OP_OUT_BAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   take;
	} dp_cmd_t;

	typedef struct packed {
		cmd_code_t cmd;
		logic      node_is_root;
		logic      load_ok;
		logic      query_ok;
		logic      idx_ge2;
		logic      idx_eq_n;
		logic      push_ok;
		logic      sp_one;
		logic      covers;
		logic      lvl_zero;
		logic      jmp_last;
	} dp_status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_CLR,
		S_LINK_INIT,
		S_LINK_CHK,
		S_LINK_P,
		S_LINK_W,
		S_DFS_RD,
		S_DFS_C,
		S_DFS_PUSH,
		S_DFS_TOP,
		S_JMP_INIT,
		S_JMP_R1,
		S_JMP_R2,
		S_JMP_W,
		S_Q_A,
		S_Q_T,
		S_Q_UP,
		S_Q_C,
		S_OUT_A,
		S_OUT_J,
		S_OUT_BAD
	} state_t;

endpackage

// ===== hdl/tlca_if.sv =====
interface tlca_req_if;
	import tlca_pkg::*;
	logic  valid;
	logic  ready;
	logic [1:0] command;
	node_t node;
	node_t parent;
	node_t other_node;
	modport source(output valid, command, node, parent, other_node, input ready);
	modport sink(input valid, command, node, parent, other_node, output ready);
endinterface

interface tlca_rsp_if;
	import tlca_pkg::*;
	logic  valid;
	logic  ready;
	node_t ancestor;
	logic  bad_id;
	modport source(output valid, ancestor, bad_id, input ready);
	modport sink(input valid, ancestor, bad_id, output ready);
endinterface

// ===== hdl/tlca_datapath.sv =====
module tlca_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tlca_pkg::dp_cmd_t    cmd,
	output tlca_pkg::dp_status_t status,
	input  logic [1:0]           in_command,
	input  tlca_pkg::node_t      in_node,
	input  tlca_pkg::node_t      in_parent,
	input  tlca_pkg::node_t      in_other,
	input  logic                 cfg_wr_en,
	input  tlca_pkg::node_t      cfg_wr_data,
	output tlca_pkg::node_t      ancestor,
	output logic                 bad_id
);
	import tlca_pkg::*;

	node_t jt_mem  [0:(LEVELS << NW)-1];
	node_t fc_mem  [0:MAX_NODES];
	node_t ns_mem  [0:MAX_NODES];
	node_t ent_mem [0:MAX_NODES];
	node_t ext_mem [0:MAX_NODES];
	node_t stk_mem [0:MAX_NODES-1];

	node_t n_q, node_q, par_q, other_q;
	logic [1:0] cmd_q;
	node_t idx_q, a_q, p_q, sp_q, tc_q, b_ent_q, b_ext_q;
	lvl_t  lvl_q;
	node_t jt_rd, fc_rd, ns_rd, ent_rd, ext_rd, stk_rd;
	node_t anc_q;
	logic  bad_q;

	logic    jt_we, jt_re, fc_we, fc_re, ns_we, ns_re, ent_we, ext_we, ee_re, stk_we, stk_re;
	logic [JW-1:0] jt_wa, jt_ra;
	node_t   jt_wd, fc_wa, fc_wd, fc_ra, ns_wa, ns_wd, ns_ra, ent_wa, ent_wd;
	node_t   ext_wa, ext_wd, ee_ra;
	logic [SW-1:0] stk_wa, stk_ra;
	node_t   stk_wd;

	node_t link_p, a_step, sp_m2;
	lvl_t  lvl_dn, q_lvl;
	logic  covers;

	assign covers = (ent_rd <= b_ent_q) && (b_ext_q <= ext_rd);
	assign link_p = (jt_rd == '0 || jt_rd >= idx_q) ? NW'(1) : jt_rd;
	assign a_step = covers ? a_q : p_q;
	assign sp_m2  = sp_q - NW'(2);
	assign lvl_dn = lvl_q - LW'(1);
	assign q_lvl  = (lvl_q == '0) ? lvl_t'(0) : lvl_dn;

	always_comb begin
		status.cmd          = cmd_code_t'(cmd_q);
		status.node_is_root = (node_q == NW'(1));
		status.load_ok      = (node_q >= NW'(2)) && (node_q <= n_q) &&
		                      (par_q >= NW'(1)) && (par_q < node_q);
		status.query_ok     = (node_q >= NW'(1)) && (node_q <= n_q) &&
		                      (other_q >= NW'(1)) && (other_q <= n_q);
		status.idx_ge2      = (idx_q >= NW'(2));
		status.idx_eq_n     = (idx_q == n_q);
		status.push_ok      = (fc_rd != '0) && (sp_q < NW'(MAX_NODES));
		status.sp_one       = (sp_q == NW'(1));
		status.covers       = covers;
		status.lvl_zero     = (lvl_q == '0);
		status.jmp_last     = (idx_q == n_q) && (lvl_q == LW'(LEVELS - 1));
	end

	// memory port steering
	always_comb begin
		jt_we = 1'b0; jt_wa = '0; jt_wd = '0; jt_re = 1'b0; jt_ra = '0;
		fc_we = 1'b0; fc_wa = '0; fc_wd = '0; fc_re = 1'b0; fc_ra = '0;
		ns_we = 1'b0; ns_wa = '0; ns_wd = '0; ns_re = 1'b0; ns_ra = '0;
		ent_we = 1'b0; ent_wa = '0; ent_wd = '0;
		ext_we = 1'b0; ext_wa = '0; ext_wd = '0;
		ee_re = 1'b0; ee_ra = '0;
		stk_we = 1'b0; stk_wa = '0; stk_wd = '0; stk_re = 1'b0; stk_ra = '0;
		case (cmd.op)
			OP_LOAD: begin
				jt_we = 1'b1; jt_wa = {lvl_t'(0), node_q}; jt_wd = par_q;
			end
			OP_CLR: begin
				fc_we = 1'b1; fc_wa = idx_q; fc_wd = '0;
			end
			OP_LINK_INIT: begin
				jt_we = 1'b1; jt_wa = {lvl_t'(0), NW'(1)}; jt_wd = NW'(1);
			end
			OP_LINK_RD: begin
				jt_re = 1'b1; jt_ra = {lvl_t'(0), idx_q};
			end
			OP_LINK_P: begin
				jt_we = (link_p != jt_rd); jt_wa = {lvl_t'(0), idx_q}; jt_wd = NW'(1);
				fc_re = 1'b1; fc_ra = link_p;
			end
			OP_LINK_W: begin
				ns_we = 1'b1; ns_wa = idx_q; ns_wd = fc_rd;
				fc_we = 1'b1; fc_wa = p_q; fc_wd = idx_q;
			end
			OP_DFS_INIT: begin
				stk_we = 1'b1; stk_wa = '0; stk_wd = NW'(1);
				ent_we = 1'b1; ent_wa = NW'(1); ent_wd = NW'(1);
			end
			OP_DFS_RD: begin
				fc_re = 1'b1; fc_ra = a_q;
			end
			OP_DFS_RDNS: begin
				ns_re = 1'b1; ns_ra = fc_rd;
			end
			OP_DFS_PUSH: begin
				fc_we = 1'b1; fc_wa = a_q; fc_wd = ns_rd;
				stk_we = 1'b1; stk_wa = sp_q[SW-1:0]; stk_wd = p_q;
				ent_we = 1'b1; ent_wa = p_q; ent_wd = tc_q;
			end
			OP_DFS_POP: begin
				ext_we = 1'b1; ext_wa = a_q; ext_wd = tc_q - NW'(1);
				stk_re = 1'b1; stk_ra = sp_m2[SW-1:0];
			end
			OP_JMP_R1: begin
				jt_re = 1'b1; jt_ra = {lvl_dn, idx_q};
			end
			OP_JMP_R2: begin
				jt_re = 1'b1; jt_ra = {lvl_dn, jt_rd};
			end
			OP_JMP_W: begin
				jt_we = 1'b1; jt_wa = {lvl_q, idx_q}; jt_wd = jt_rd;
			end
			OP_Q_RD_B: begin
				ee_re = 1'b1; ee_ra = other_q;
			end
			OP_Q_RD_A: begin
				ee_re = 1'b1; ee_ra = a_q;
			end
			OP_Q_LOOP: begin
				jt_re = 1'b1; jt_ra = {LW'(LEVELS - 1), a_q};
			end
			OP_Q_UP: begin
				ee_re = 1'b1; ee_ra = jt_rd;
			end
			OP_Q_STEP: begin
				jt_re = 1'b1; jt_ra = {q_lvl, a_step};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (jt_we) jt_mem[jt_wa] <= jt_wd;
		if (jt_re) jt_rd <= jt_mem[jt_ra];
		if (fc_we) fc_mem[fc_wa] <= fc_wd;
		if (fc_re) fc_rd <= fc_mem[fc_ra];
		if (ns_we) ns_mem[ns_wa] <= ns_wd;
		if (ns_re) ns_rd <= ns_mem[ns_ra];
		if (ent_we) ent_mem[ent_wa] <= ent_wd;
		if (ext_we) ext_mem[ext_wa] <= ext_wd;
		if (ee_re) begin
			ent_rd <= ent_mem[ee_ra];
			ext_rd <= ext_mem[ee_ra];
		end
		if (stk_we) stk_mem[stk_wa] <= stk_wd;
		if (stk_re) stk_rd <= stk_mem[stk_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= NW'(1);
		end else if (cfg_wr_en) begin
			if (cfg_wr_data == '0)
				n_q <= NW'(1);
			else if (cfg_wr_data > NW'(MAX_NODES))
				n_q <= NW'(MAX_NODES);
			else
				n_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
			tc_q <= NW'(1);
		end else begin
			case (cmd.op)
				OP_DFS_INIT: begin
					sp_q <= NW'(1);
					tc_q <= NW'(2);
				end
				OP_DFS_PUSH: begin
					sp_q <= sp_q + NW'(1);
					tc_q <= tc_q + NW'(1);
				end
				OP_DFS_POP: sp_q <= sp_q - NW'(1);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cmd_q   <= in_command;
			node_q  <= in_node;
			par_q   <= in_parent;
			other_q <= in_other;
		end
		case (cmd.op)
			OP_CLR_INIT:  idx_q <= NW'(1);
			OP_CLR:       idx_q <= idx_q + NW'(1);
			OP_LINK_INIT: idx_q <= n_q;
			OP_LINK_P:    p_q <= link_p;
			OP_LINK_W:    idx_q <= idx_q - NW'(1);
			OP_DFS_INIT:  a_q <= NW'(1);
			OP_DFS_RDNS:  p_q <= fc_rd;
			OP_DFS_PUSH:  a_q <= p_q;
			OP_DFS_TOP:   a_q <= stk_rd;
			OP_JMP_INIT: begin
				idx_q <= NW'(1);
				lvl_q <= LW'(1);
			end
			OP_JMP_W: begin
				if (idx_q == n_q) begin
					idx_q <= NW'(1);
					lvl_q <= lvl_q + LW'(1);
				end else begin
					idx_q <= idx_q + NW'(1);
				end
			end
			OP_Q_RD_B:    a_q <= node_q;
			OP_Q_RD_A: begin
				b_ent_q <= ent_rd;
				b_ext_q <= ext_rd;
			end
			OP_Q_LOOP:    lvl_q <= LW'(LEVELS - 1);
			OP_Q_UP:      p_q <= jt_rd;
			OP_Q_STEP: begin
				a_q <= a_step;
				lvl_q <= q_lvl;
			end
			OP_OUT_A: begin
				anc_q <= a_q;
				bad_q <= 1'b0;
			end
			OP_OUT_J: begin
				anc_q <= jt_rd;
				bad_q <= 1'b0;
			end
			OP_OUT_BAD: begin
				anc_q <= '0;
				bad_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign ancestor = anc_q;
	assign bad_id   = bad_q;

	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= NW'(MAX_NODES))
		else $error("walk stack pointer past its depth");
	a_dfs_init: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_DFS_INIT |=> sp_q == NW'(1) && tc_q == NW'(2))
		else $error("walk did not start with the root alone on the stack");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_DFS_POP |-> sp_q != '0)
		else $error("pop from an empty walk stack");
	a_jmp_lvl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_JMP_W |-> lvl_q != '0 && lvl_q < LW'(LEVELS))
		else $error("jump fill level out of range");
endmodule

// ===== hdl/tlca_ctrl.sv =====
module tlca_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  logic                 cfg_wr_en,
	input  tlca_pkg::dp_status_t status,
	output tlca_pkg::dp_cmd_t    cmd
);
	import tlca_pkg::*;

	state_t state_q, state_n;
	logic   built_q, rsp_valid_q;
	logic   out_free, emit, set_built, clr_built;

	assign out_free = !rsp_valid_q || rsp_ready;
	assign emit = out_free &&
	              (state_q == S_OUT_A || state_q == S_OUT_J || state_q == S_OUT_BAD);

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE:      if (req_valid) state_n = S_DECODE;
			S_DECODE: begin
				case (status.cmd)
					CMD_LOAD: begin
						if (status.node_is_root || status.load_ok)
							state_n = S_IDLE;
						else
							state_n = S_OUT_BAD;
					end
					CMD_BUILD: state_n = S_CLR;
					CMD_QUERY: state_n = (built_q && status.query_ok) ? S_Q_A : S_OUT_BAD;
					default:   state_n = S_IDLE;
				endcase
			end
			S_CLR:       if (status.idx_eq_n) state_n = S_LINK_INIT;
			S_LINK_INIT: state_n = S_LINK_CHK;
			S_LINK_CHK:  state_n = status.idx_ge2 ? S_LINK_P : S_DFS_RD;
			S_LINK_P:    state_n = S_LINK_W;
			S_LINK_W:    state_n = S_LINK_CHK;
			S_DFS_RD:    state_n = S_DFS_C;
			S_DFS_C: begin
				if (status.push_ok)
					state_n = S_DFS_PUSH;
				else
					state_n = status.sp_one ? S_JMP_INIT : S_DFS_TOP;
			end
			S_DFS_PUSH:  state_n = S_DFS_RD;
			S_DFS_TOP:   state_n = S_DFS_RD;
			S_JMP_INIT:  state_n = (LEVELS == 1) ? S_IDLE : S_JMP_R1;
			S_JMP_R1:    state_n = S_JMP_R2;
			S_JMP_R2:    state_n = S_JMP_W;
			S_JMP_W:     state_n = status.jmp_last ? S_IDLE : S_JMP_R1;
			S_Q_A:       state_n = S_Q_T;
			S_Q_T:       state_n = status.covers ? S_OUT_A : S_Q_UP;
			S_Q_UP:      state_n = S_Q_C;
			S_Q_C:       state_n = status.lvl_zero ? S_OUT_J : S_Q_UP;
			S_OUT_A, S_OUT_J, S_OUT_BAD: if (out_free) state_n = S_IDLE;
			default:     state_n = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op    = OP_NONE;
		cmd.take  = 1'b0;
		req_ready = (state_q == S_IDLE);
		set_built = 1'b0;
		clr_built = 1'b0;
		case (state_q)
			S_IDLE: cmd.take = req_valid;
			S_DECODE: begin
				case (status.cmd)
					CMD_LOAD: begin
						if (!status.node_is_root && status.load_ok) begin
							cmd.op    = OP_LOAD;
							clr_built = 1'b1;
						end
					end
					CMD_BUILD: cmd.op = OP_CLR_INIT;
					CMD_QUERY: if (built_q && status.query_ok) cmd.op = OP_Q_RD_B;
					default: begin
					end
				endcase
			end
			S_CLR:       cmd.op = OP_CLR;
			S_LINK_INIT: cmd.op = OP_LINK_INIT;
			S_LINK_CHK:  cmd.op = status.idx_ge2 ? OP_LINK_RD : OP_DFS_INIT;
			S_LINK_P:    cmd.op = OP_LINK_P;
			S_LINK_W:    cmd.op = OP_LINK_W;
			S_DFS_RD:    cmd.op = OP_DFS_RD;
			S_DFS_C:     cmd.op = status.push_ok ? OP_DFS_RDNS : OP_DFS_POP;
			S_DFS_PUSH:  cmd.op = OP_DFS_PUSH;
			S_DFS_TOP:   cmd.op = OP_DFS_TOP;
			S_JMP_INIT: begin
				cmd.op    = OP_JMP_INIT;
				set_built = (LEVELS == 1);
			end
			S_JMP_R1:    cmd.op = OP_JMP_R1;
			S_JMP_R2:    cmd.op = OP_JMP_R2;
			S_JMP_W: begin
				cmd.op    = OP_JMP_W;
				set_built = status.jmp_last;
			end
			S_Q_A:       cmd.op = OP_Q_RD_A;
			S_Q_T:       cmd.op = status.covers ? OP_NONE : OP_Q_LOOP;
			S_Q_UP:      cmd.op = OP_Q_UP;
			S_Q_C:       cmd.op = OP_Q_STEP;
			S_OUT_A:     if (out_free) cmd.op = OP_OUT_A;
			S_OUT_J:     if (out_free) cmd.op = OP_OUT_J;
			S_OUT_BAD:   if (out_free) cmd.op = OP_OUT_BAD;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			built_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_wr_en || clr_built)
				built_q <= 1'b0;
			else if (set_built)
				built_q <= 1'b1;
			if (emit)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_OUT_A || state_q == S_OUT_J ||
		                             state_q == S_OUT_BAD))
		else $error("result raised outside a result state");
	a_built_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(built_q) |-> $past(state_q == S_JMP_W || state_q == S_JMP_INIT))
		else $error("tables marked built before the jump fill ended");
	a_no_lost: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !rsp_valid_q || rsp_ready)
		else $error("result overwritten while still waiting");
endmodule

// ===== hdl/tree_lca_binary_lifting.sv =====
// Channel  Dir  Payload                                 Accepted at
// req      in   command, node, parent, other_node       req.valid & req.ready
// rsp      out  ancestor, bad_id                        rsp.valid & rsp.ready
// cfg      in   cfg_wr_data (num_nodes)                 cfg_wr_en
//
// Load and unused commands go back to idle from decode; a rejected item gets a result.
// Query: no climb when node covers other_node; else it climbs every level with
// two dependent reads per level, of the jump table and the time tables.
// Build: clear, link, depth-first walk and jump fill, bound by one port per table.
// Reset inits control, num_nodes, walk counters only; the build clears child lists.
// A waiting result does not block the next item; a new result waits for the old.
module tree_lca_binary_lifting (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  tlca_pkg::node_t     cfg_wr_data,
	tlca_req_if.sink            req,
	tlca_rsp_if.source          rsp
);
	import tlca_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// sequence decode, build walk, jump fill and query climb
	tlca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cfg_wr_en (cfg_wr_en),
		.status    (status),
		.cmd       (cmd)
	);

	// hold the tables, walk stack, counters and result register
	tlca_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.in_command  (req.command),
		.in_node     (req.node),
		.in_parent   (req.parent),
		.in_other    (req.other_node),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.ancestor    (rsp.ancestor),
		.bad_id      (rsp.bad_id)
	);
endmodule

// ===== sim/tb_tree_lca_binary_lifting.sv =====
`timescale 1ns / 100ps

module tb_tree_lca_binary_lifting;
	import tlca_pkg::*;

	localparam int RUN_LIMIT  = 10_000_000;  // cycles before the run is called hung
	localparam int ITEM_GOAL  = 1150;
	localparam int SETTLE     = 40;          // cycles to let a resultless item drain
	localparam int IDLE_PCT   = 34;

	typedef struct packed {
		node_t ancestor;
		logic  bad_id;
	} lca_answer_t;

	// One row of the directed table: either a register write or an item,
	// with an answer typed in where it is obvious.
	typedef struct packed {
		logic      is_cfg;
		node_t     cfg_value;
		cmd_code_t cmd;
		node_t     node;
		node_t     parent;
		node_t     other_node;
		logic      fixed;
		node_t     ancestor;
		logic      bad_id;
	} dir_row_t;

	localparam int DIR_ROWS = 31;
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		// reset state: one node, nothing built
		'{1'b0, 11'd0, CMD_QUERY, 11'd1,    11'd0,    11'd1,    1'b1, 11'd0, 1'b1},
		'{1'b0, 11'd0, CMD_LOAD,  11'd1,    11'd1,    11'd0,    1'b0, 11'd0, 1'b0},
		'{1'b0, 11'd0, CMD_LOAD,  11'd2,    11'd1,    11'd0,    1'b1, 11'd0, 1'b1},
		'{1'b0, 11'd0, CMD_NONE,  11'd2047, 11'd2047, 11'd2047, 1'b0, 11'd0, 1'b0},
		'{1'b0, 11'd0, CMD_BUILD, 11'd0,    11'd0,    11'd0,    1'b0, 11'd0, 1'b0},
		'{1'b0, 11'd0, CMD_QUERY, 11'd1,    11'd0,    11'd1,    1'b0, 11'd0, 1'b0},
		'{1'b0, 11'd0, CMD_QUERY, 11'd2047, 11'd0,    11'd1,    1'b1, 11'd0, 1'b1},
		// eight-node tree
		'{1'b1, 11'd8, CMD_LOAD,  11'd0,    11'd0,    11'd0,    1'b0, 11'd0, 1'b0},
		'{1'b0, 11'd0, CMD_LOAD,  11'd2,    11'd1,    11'd0,    1'b0, 11'd0, 1'b0},
		'{1'b0, 11'd0, CMD_LOAD,  11'd3,    11'd2,    11'd0,    1'b0, 11'd0, 1'b0},
		'{1'b0, 11'd0, CMD_LOAD,  11'd4,    11'd1,    11'd0,    1'b0, 11'd0, 1'b0},
		'{1'b0, 11'd0, CMD_LOAD,  11'd5,    11'd3,    11'd0,    1'b0, 11'd0, 1'b0},
		'{1'b0, 11'd0, CMD_LOAD,  11'd6,    11'd5,    11'd0,    1'b0, 11'd0, 1'b0},
		'{1'b0, 11'd0, CMD_LOAD,  11'd7,    11'd4,    11'd0,    1'b0, 11'd0, 1'b0},
		'{1'b0, 11'd0, CMD_LOAD,  11'd8,    11'd7,    11'd0,    1'b0, 11'd0, 1'b0},
		'{1'b0, 11'd0, CMD_LOAD,  11'd8,    11'd0,    11'd0,    1'b1, 11'd0, 1'b1},
		'{1'b0, 11'd0, CMD_LOAD,  11'd5,    11'd5,    11'd0,    1'b1, 11'd0, 1'b1},
		'{1'b0, 11'd0, CMD_LOAD,  11'd9,    11'd1,    11'd0,    1'b1, 11'd0, 1'b1},
		'{1'b0, 11'd0, CMD_QUERY, 11'd6,    11'd0,    11'd8,    1'b1, 11'd0, 1'b1},
		'{1'b0, 11'd0, CMD_BUILD, 11'd0,    11'd0,    11'd0,    1'b0, 11'd0, 1'b0},
		'{1'b0, 11'd0, CMD_QUERY, 11'd6,    11'd0,    11'd8,    1'b0, 11'd0, 1'b0},
		'{1'b0, 11'd0, CMD_QUERY, 11'd1,    11'd0,    11'd8,    1'b0, 11'd0, 1'b0},
		'{1'b0, 11'd0, CMD_QUERY, 11'd8,    11'd0,    11'd8,    1'b0, 11'd0, 1'b0},
		'{1'b0, 11'd0, CMD_QUERY, 11'd0,    11'd0,    11'd3,    1'b1, 11'd0, 1'b1},
		'{1'b0, 11'd0, CMD_QUERY, 11'd3,    11'd0,    11'd2047, 1'b1, 11'd0, 1'b1},
		// saturating writes at both ends
		'{1'b1, 11'd0, CMD_LOAD,  11'd0,    11'd0,    11'd0,    1'b0, 11'd0, 1'b0},
		'{1'b0, 11'd0, CMD_QUERY, 11'd1,    11'd0,    11'd1,    1'b1, 11'd0, 1'b1},
		'{1'b1, 11'd2047, CMD_LOAD, 11'd0,  11'd0,    11'd0,    1'b0, 11'd0, 1'b0},
		'{1'b0, 11'd0, CMD_QUERY, 11'd1024, 11'd0,    11'd1,    1'b1, 11'd0, 1'b1},
		'{1'b0, 11'd0, CMD_LOAD,  11'd1024, 11'd1023, 11'd0,    1'b0, 11'd0, 1'b0},
		'{1'b0, 11'd0, CMD_LOAD,  11'd1024, 11'd2047, 11'd0,    1'b1, 11'd0, 1'b1}
	};

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	node_t cfg_wr_data;

	tlca_req_if req ();
	tlca_rsp_if rsp ();

	tree_lca_binary_lifting dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req.sink),
		.rsp         (rsp.source)
	);

	// Shadow copy of the tree state.
	node_t jump [0:MAX_NODES][0:LEVELS-1];
	node_t kid_head [0:MAX_NODES];
	node_t sibling [0:MAX_NODES];
	node_t t_in [0:MAX_NODES];
	node_t t_out [0:MAX_NODES];
	node_t dfs_stack [0:MAX_NODES-1];
	logic  has_parent [0:MAX_NODES];
	logic  built;
	int    node_count;

	lca_answer_t pending_answers [$];
	int  fail_count;
	int  item_count;
	int  cycle_count;
	logic calm;       // no idling on either side while set

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hold the run to a hard cycle budget.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result side: stall at random, compare every accepted item in order.
	always @(posedge clk) begin
		lca_answer_t want;
		if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (pending_answers.size() == 0) begin
				$error("unexpected result: ancestor %0d bad_id %0d", rsp.ancestor, rsp.bad_id);
				fail_count = fail_count + 1;
			end else begin
				want = pending_answers.pop_front();
				if (rsp.ancestor !== want.ancestor) begin
					$error("ancestor: expected %0d, got %0d", want.ancestor, rsp.ancestor);
					fail_count = fail_count + 1;
				end
				if (rsp.bad_id !== want.bad_id) begin
					$error("bad_id: expected %0d, got %0d", want.bad_id, rsp.bad_id);
					fail_count = fail_count + 1;
				end
			end
		end
		rsp.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
	end

	function automatic logic encloses(node_t outer, node_t inner);
		return t_in[outer] <= t_in[inner] && t_out[inner] <= t_out[outer];
	endfunction

	// Link children, walk depth-first with an explicit stack, then fill the jump levels.
	function automatic void rebuild_tree();
		int    sp;
		node_t p;
		node_t u;
		node_t c;
		node_t tick;
		jump[1][0] = node_t'(1);
		for (int i = 1; i <= node_count; i++)
			kid_head[i] = '0;
		for (int i = node_count; i >= 2; i--) begin
			p = jump[i][0];
			if (p == 0 || p >= i) begin
				p = node_t'(1);
				jump[i][0] = node_t'(1);
			end
			sibling[i] = kid_head[p];
			kid_head[p] = node_t'(i);
		end
		tick = node_t'(1);
		sp = 0;
		dfs_stack[sp] = node_t'(1);
		sp++;
		t_in[1] = tick;
		tick++;
		while (sp > 0) begin
			u = dfs_stack[sp-1];
			c = kid_head[u];
			if (c != 0 && sp < MAX_NODES) begin
				kid_head[u] = sibling[c];
				dfs_stack[sp] = c;
				sp++;
				t_in[c] = tick;
				tick++;
			end else begin
				sp--;
				t_out[u] = tick - node_t'(1);
			end
		end
		for (int k = 1; k < LEVELS; k++)
			for (int i = 1; i <= node_count; i++)
				jump[i][k] = jump[jump[i][k-1]][k-1];
		built = 1'b1;
	endfunction

	function automatic node_t common_ancestor(node_t a, node_t b);
		node_t up;
		if (encloses(a, b))
			return a;
		for (int v = LEVELS - 1; v >= 0; v--) begin
			up = jump[a][v];
			if (!encloses(up, b))
				a = up;
		end
		return jump[a][0];
	endfunction

	// Advance the shadow state by one item; return 1 with the answer if it makes one.
	function automatic logic step_tree(cmd_code_t cmd, node_t a, node_t p, node_t b,
			output lca_answer_t ans);
		ans = '{ancestor: '0, bad_id: 1'b1};
		case (cmd)
			CMD_LOAD: begin
				if (a == 1)
					return 1'b0;
				if (a < 2 || a > node_count || p < 1 || p >= a)
					return 1'b1;
				jump[a][0] = p;
				has_parent[a] = 1'b1;
				built = 1'b0;
				return 1'b0;
			end
			CMD_BUILD: begin
				rebuild_tree();
				return 1'b0;
			end
			CMD_QUERY: begin
				if (!built || a < 1 || a > node_count || b < 1 || b > node_count)
					return 1'b1;
				ans = '{ancestor: common_ancestor(a, b), bad_id: 1'b0};
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Drive one item, idling at random first; predict it once accepted.
	task automatic send_item(cmd_code_t cmd, node_t a, node_t p, node_t b,
			logic fixed = 1'b0, lca_answer_t typed = '0);
		lca_answer_t ans;
		logic        makes;
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid      <= 1'b1;
		req.command    <= cmd;
		req.node       <= a;
		req.parent     <= p;
		req.other_node <= b;
		do
			@(posedge clk);
		while (req.ready !== 1'b1);
		makes = step_tree(cmd, a, p, b, ans);
		if (fixed)
			ans = typed;
		if (makes)
			pending_answers.insert(pending_answers.size(), ans);
		if (cmd != CMD_NONE && !(cmd == CMD_LOAD && a == 1))
			item_count++;
	endtask

	// Write num_nodes once the block has drained.
	task automatic write_node_count(node_t value);
		req.valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		node_count = (value < 1) ? 1 : (value > MAX_NODES) ? MAX_NODES : int'(value);
		built = 1'b0;
	endtask

	function automatic node_t pick_parent(int child);
		return ($urandom_range(0, 3) == 0) ? node_t'(child - 1) :
			node_t'($urandom_range(1, child - 1));
	endfunction

	// Malformed or ignored items: bad loads, root loads, unused command, raw queries.
	task automatic send_noise();
		case ($urandom_range(0, 4))
			0: send_item(CMD_LOAD, node_t'($urandom_range(node_count + 1, 2047)),
				node_t'($urandom_range(1, 2047)), node_t'($urandom));
			1: send_item(CMD_LOAD, node_t'($urandom_range(2, 2047)), '0, node_t'($urandom));
			2: send_item(CMD_LOAD, 11'd1, node_t'($urandom), node_t'($urandom));
			3: send_item(CMD_NONE, node_t'($urandom), node_t'($urandom), node_t'($urandom));
			default: send_item(CMD_QUERY, node_t'($urandom), node_t'($urandom),
				node_t'($urandom));
		endcase
	endtask

	task automatic send_good_query();
		node_t a;
		node_t b;
		a = ($urandom_range(0, 9) == 0) ? node_t'(node_count) : node_t'($urandom_range(1, node_count));
		b = ($urandom_range(0, 9) == 0) ? 11'd1 : node_t'($urandom_range(1, node_count));
		send_item(CMD_QUERY, a, node_t'($urandom), b);
	endtask

	// One phase: set the size, load every missing parent among noise, build, query.
	task automatic run_phase(int phase_no);
		node_t setting;
		int    r;
		int    pick;
		if (phase_no == 4)
			setting = ($urandom_range(0, 1) == 0) ? 11'd1024 : 11'd2047;
		else if (phase_no % 9 == 5)
			setting = ($urandom_range(0, 1) == 0) ? 11'd0 : 11'd1;
		else
			setting = node_t'($urandom_range(2, 48));
		write_node_count(setting);
		for (int i = 2; i <= node_count; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_noise();
			if (!has_parent[i])
				send_item(CMD_LOAD, node_t'(i), pick_parent(i), node_t'($urandom));
		end
		repeat ($urandom_range(0, (node_count < 80) ? node_count / 4 : 20)) begin
			if (node_count >= 2) begin
				pick = $urandom_range(2, node_count);
				send_item(CMD_LOAD, node_t'(pick), pick_parent(pick), node_t'($urandom));
			end
		end
		send_item(CMD_BUILD, node_t'($urandom), node_t'($urandom), node_t'($urandom));
		repeat ($urandom_range(10, 40)) begin
			r = $urandom_range(0, 99);
			if (r < 5 && node_count >= 2) begin
				// reload one parent; queries fail until the next build
				pick = $urandom_range(2, node_count);
				send_item(CMD_LOAD, node_t'(pick), pick_parent(pick), node_t'($urandom));
				send_good_query();
				send_item(CMD_BUILD, node_t'($urandom), node_t'($urandom), node_t'($urandom));
			end else if (r < 15) begin
				send_noise();
			end else begin
				send_good_query();
			end
		end
		send_good_query();  // end on an item that answers, so the drain is visible
	endtask

	initial begin
		lca_answer_t typed;
		int          phase_no;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		req.valid   = 1'b0;
		req.command = CMD_NONE;
		req.node    = '0;
		req.parent  = '0;
		req.other_node = '0;
		rsp.ready   = 1'b0;
		calm        = 1'b0;
		fail_count  = 0;
		item_count  = 0;
		cycle_count = 0;
		built       = 1'b0;
		node_count  = 1;
		for (int i = 0; i <= MAX_NODES; i++) begin
			for (int k = 0; k < LEVELS; k++)
				jump[i][k] = '0;
			kid_head[i] = '0;
			sibling[i] = '0;
			t_in[i] = '0;
			t_out[i] = '0;
			has_parent[i] = 1'b0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table.
		foreach (DIR_TABLE[i]) begin
			if (DIR_TABLE[i].is_cfg) begin
				write_node_count(DIR_TABLE[i].cfg_value);
			end else begin
				typed = '{ancestor: DIR_TABLE[i].ancestor, bad_id: DIR_TABLE[i].bad_id};
				send_item(DIR_TABLE[i].cmd, DIR_TABLE[i].node, DIR_TABLE[i].parent,
					DIR_TABLE[i].other_node, DIR_TABLE[i].fixed, typed);
			end
		end

		// Random phases; phase 2 runs with no idling at all.
		phase_no = 0;
		while (item_count < ITEM_GOAL) begin
			calm = (phase_no == 2);
			run_phase(phase_no);
			phase_no++;
		end
		calm = 1'b0;
		req.valid <= 1'b0;

		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && pending_answers.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
